[src/rvdec_pkg.sv]
// ----------------------------------------------------------------------------
// rvdec_pkg
// Shared opcodes, result codes and the decoded-result record of the RV32IM
// instruction decoder.
// ----------------------------------------------------------------------------
package rvdec_pkg;

  // Major opcodes (bits 6:0)
  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
  localparam logic [6:0] OPC_SYSTEM = 7'b1110011;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_OP     = 7'b0110011;

  localparam logic [31:0] UPPER_MASK = 32'hFFFF_F000;
  localparam logic [6:0]  F7_BASE    = 7'h00;
  localparam logic [6:0]  F7_ALT     = 7'h20;
  localparam logic [6:0]  F7_MULDIV  = 7'h01;

  // Instruction formats
  localparam logic [2:0] FMT_NONE = 3'd0;
  localparam logic [2:0] FMT_U    = 3'd1;
  localparam logic [2:0] FMT_J    = 3'd2;
  localparam logic [2:0] FMT_I    = 3'd3;
  localparam logic [2:0] FMT_B    = 3'd4;
  localparam logic [2:0] FMT_S    = 3'd5;
  localparam logic [2:0] FMT_R    = 3'd6;

  // Issue units
  localparam logic [2:0] UNIT_ALU   = 3'd0;
  localparam logic [2:0] UNIT_MDU   = 3'd1;
  localparam logic [2:0] UNIT_JUMP  = 3'd2;
  localparam logic [2:0] UNIT_LOAD  = 3'd3;
  localparam logic [2:0] UNIT_STORE = 3'd4;
  localparam logic [2:0] UNIT_CSR   = 3'd5;

  // ALU operations
  localparam logic [3:0] ALU_ADD   = 4'd0;
  localparam logic [3:0] ALU_SUB   = 4'd1;
  localparam logic [3:0] ALU_SLL   = 4'd2;
  localparam logic [3:0] ALU_SLT   = 4'd3;
  localparam logic [3:0] ALU_SLT_U = 4'd4;
  localparam logic [3:0] ALU_XOR   = 4'd5;
  localparam logic [3:0] ALU_SRL   = 4'd6;
  localparam logic [3:0] ALU_SRA   = 4'd7;
  localparam logic [3:0] ALU_OR    = 4'd8;
  localparam logic [3:0] ALU_AND   = 4'd9;
  localparam logic [3:0] ALU_LUI   = 4'd10;
  localparam logic [3:0] ALU_AUIPC = 4'd11;

  // Multiply/divide operations
  localparam logic [3:0] MDU_MUL  = 4'd0;
  localparam logic [3:0] MDU_DIV  = 4'd1;
  localparam logic [3:0] MDU_DIVU = 4'd2;
  localparam logic [3:0] MDU_REM  = 4'd3;

  // Jump and branch operations
  localparam logic [3:0] JMP_JAL  = 4'd0;
  localparam logic [3:0] JMP_JALR = 4'd1;
  localparam logic [3:0] JMP_BEQ  = 4'd2;
  localparam logic [3:0] JMP_BNE  = 4'd3;
  localparam logic [3:0] JMP_BLT  = 4'd4;
  localparam logic [3:0] JMP_BGE  = 4'd5;
  localparam logic [3:0] JMP_BLTU = 4'd6;
  localparam logic [3:0] JMP_BGEU = 4'd7;

  // Load and store operations
  localparam logic [3:0] LD_LB  = 4'd0;
  localparam logic [3:0] LD_LH  = 4'd1;
  localparam logic [3:0] LD_LW  = 4'd2;
  localparam logic [3:0] LD_LBU = 4'd3;
  localparam logic [3:0] LD_LHU = 4'd4;
  localparam logic [3:0] ST_SB  = 4'd0;
  localparam logic [3:0] ST_SH  = 4'd1;
  localparam logic [3:0] ST_SW  = 4'd2;

  // CSR / system operations
  localparam logic [3:0] CSR_SYS = 4'd0;
  localparam logic [3:0] CSR_RW  = 4'd1;
  localparam logic [3:0] CSR_RS  = 4'd2;
  localparam logic [3:0] CSR_RC  = 4'd3;

  // Packed width of one decoded result on the master stream
  localparam int RESULT_BITS = 62;
  localparam int OUT_BYTES   = (RESULT_BITS + 7) / 8;

  typedef struct packed {
    logic [2:0]  format_kind;
    logic [2:0]  issue_unit;
    logic [3:0]  operation;
    logic        legal;
    logic [4:0]  src1_reg;
    logic [4:0]  src2_reg;
    logic [4:0]  dest_reg;
    logic [31:0] immediate;
    logic        uses_immediate;
    logic        uses_src1;
    logic        uses_src2;
    logic        uses_dest;
  } decode_t;

endpackage

[src/rvdec_core.sv]
// ----------------------------------------------------------------------------
// rvdec_core
// Combinational decode of one RV32IM instruction word into format, issue
// unit, operation, register indices, immediate and operand-use flags.
// ----------------------------------------------------------------------------
module rvdec_core (
  input  logic [31:0]             instruction,
  output rvdec_pkg::decode_t      result
);
  import rvdec_pkg::*;

  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_j;
  logic [31:0] imm_shamt;
  logic [2:0]  fmt;
  logic [2:0]  unit;
  logic [3:0]  op;
  logic        ok;
  logic [31:0] imm;
  logic        ui;
  logic        u1;
  logic        u2;
  logic        ud;
  logic [3:0]  alu_code;
  logic        alu_ok;
  logic        reg_form;

  // Field slices and the immediate of every format
  assign opc       = instruction[6:0];
  assign f3        = instruction[14:12];
  assign f7        = instruction[31:25];
  assign imm_i     = {{20{instruction[31]}}, instruction[31:20]};
  assign imm_s     = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
  assign imm_b     = {{19{instruction[31]}}, instruction[31], instruction[7],
                      instruction[30:25], instruction[11:8], 1'b0};
  assign imm_j     = {{11{instruction[31]}}, instruction[31], instruction[19:12],
                      instruction[20], instruction[30:21], 1'b0};
  assign imm_shamt = {27'd0, instruction[24:20]};
  assign reg_form  = (opc == OPC_OP);

  // ALU operation shared by register and immediate forms
  always_comb begin
    alu_code = ALU_ADD;
    alu_ok   = 1'b0;
    case (f3)
      3'd0: begin
        if (!reg_form || f7 == F7_BASE) begin
          alu_code = ALU_ADD;
          alu_ok   = 1'b1;
        end else if (f7 == F7_ALT) begin
          alu_code = ALU_SUB;
          alu_ok   = 1'b1;
        end
      end
      3'd1: begin
        alu_code = ALU_SLL;
        alu_ok   = (f7 == F7_BASE);
      end
      3'd2: begin
        alu_code = ALU_SLT;
        alu_ok   = !reg_form || f7 == F7_BASE;
      end
      3'd3: begin
        alu_code = ALU_SLT_U;
        alu_ok   = !reg_form || f7 == F7_BASE;
      end
      3'd4: begin
        alu_code = ALU_XOR;
        alu_ok   = !reg_form || f7 == F7_BASE;
      end
      3'd5: begin
        alu_code = (f7 == F7_ALT) ? ALU_SRA : ALU_SRL;
        alu_ok   = (f7 == F7_BASE) || (f7 == F7_ALT);
      end
      3'd6: begin
        alu_code = ALU_OR;
        alu_ok   = !reg_form || f7 == F7_BASE;
      end
      default: begin
        alu_code = ALU_AND;
        alu_ok   = !reg_form || f7 == F7_BASE;
      end
    endcase
  end

  // Classify the opcode and pick unit, operation and operands
  always_comb begin
    fmt  = FMT_NONE;
    unit = UNIT_ALU;
    op   = 4'd0;
    ok   = 1'b0;
    imm  = 32'd0;
    ui   = 1'b0;
    u1   = 1'b0;
    u2   = 1'b0;
    ud   = 1'b0;
    case (opc)
      OPC_LUI, OPC_AUIPC: begin
        fmt  = FMT_U;
        unit = UNIT_ALU;
        op   = (opc == OPC_LUI) ? ALU_LUI : ALU_AUIPC;
        ok   = 1'b1;
        imm  = instruction & UPPER_MASK;
        ui   = 1'b1;
        ud   = 1'b1;
      end
      OPC_JAL: begin
        fmt  = FMT_J;
        unit = UNIT_JUMP;
        op   = JMP_JAL;
        ok   = 1'b1;
        imm  = imm_j;
        ui   = 1'b1;
        ud   = 1'b1;
      end
      OPC_JALR: begin
        fmt  = FMT_I;
        unit = UNIT_JUMP;
        op   = JMP_JALR;
        ok   = (f3 == 3'd0);
        imm  = imm_i;
        ui   = 1'b1;
        u1   = 1'b1;
        ud   = 1'b1;
      end
      OPC_LOAD: begin
        fmt  = FMT_I;
        unit = UNIT_LOAD;
        imm  = imm_i;
        ui   = 1'b1;
        u1   = 1'b1;
        ud   = 1'b1;
        if (f3 <= 3'd2) begin
          op = {1'b0, f3};
          ok = 1'b1;
        end else if (f3 == 3'd4 || f3 == 3'd5) begin
          op = {1'b0, f3 - 3'd1};
          ok = 1'b1;
        end
      end
      OPC_OPIMM: begin
        fmt  = FMT_I;
        unit = UNIT_ALU;
        op   = alu_code;
        ok   = alu_ok;
        imm  = (f3 == 3'd1 || f3 == 3'd5) ? imm_shamt : imm_i;
        ui   = 1'b1;
        u1   = 1'b1;
        ud   = 1'b1;
      end
      OPC_SYSTEM: begin
        fmt  = FMT_I;
        unit = UNIT_CSR;
        op   = {1'b0, f3};
        ok   = !f3[2];
        imm  = imm_i;
        ui   = 1'b1;
        u1   = 1'b1;
        ud   = 1'b1;
      end
      OPC_BRANCH: begin
        fmt  = FMT_B;
        unit = UNIT_JUMP;
        imm  = imm_b;
        ui   = 1'b1;
        u1   = 1'b1;
        u2   = 1'b1;
        if (f3 == 3'd0 || f3 == 3'd1) begin
          op = {1'b0, f3} + JMP_BEQ;
          ok = 1'b1;
        end else if (f3[2]) begin
          op = {1'b0, f3};
          ok = 1'b1;
        end
      end
      OPC_STORE: begin
        fmt  = FMT_S;
        unit = UNIT_STORE;
        op   = {1'b0, f3};
        ok   = (f3 <= 3'd2);
        imm  = imm_s;
        ui   = 1'b1;
        u1   = 1'b1;
        u2   = 1'b1;
      end
      OPC_OP: begin
        fmt = FMT_R;
        u1  = 1'b1;
        u2  = 1'b1;
        ud  = 1'b1;
        if (f7 == F7_MULDIV) begin
          unit = UNIT_MDU;
          if (f3 == 3'd0) begin
            op = MDU_MUL;
            ok = 1'b1;
          end else if (f3 >= 3'd4 && f3 <= 3'd6) begin
            op = {1'b0, f3 - 3'd3};
            ok = 1'b1;
          end
        end else begin
          unit = UNIT_ALU;
          op   = alu_code;
          ok   = alu_ok;
        end
      end
      default: begin
        fmt = FMT_NONE;
      end
    endcase
  end

  // Zero everything that the format does not use
  always_comb begin
    result.format_kind    = fmt;
    result.issue_unit     = unit;
    result.operation      = ok ? op : 4'd0;
    result.legal          = ok;
    result.src1_reg       = u1 ? instruction[19:15] : 5'd0;
    result.src2_reg       = u2 ? instruction[24:20] : 5'd0;
    result.dest_reg       = ud ? instruction[11:7] : 5'd0;
    result.immediate      = ui ? imm : 32'd0;
    result.uses_immediate = ui;
    result.uses_src1      = u1;
    result.uses_src2      = u2;
    result.uses_dest      = ud;
  end

endmodule

[src/rv32im_instruction_decoder.sv]
// ----------------------------------------------------------------------------
// rv32im_instruction_decoder
// Streaming RV32IM instruction decoder: instruction words in, decoded
// records out.
// ----------------------------------------------------------------------------
// Accepts one instruction word per clock cycle unless the output stalls
// it: the word is captured in an input register, decoded by a single pass
// of combinational logic, and the record is held in a result register
// until the downstream side takes it. Throughput is one instruction per
// cycle, through those two register stages. Back-pressure on the output
// stalls both stages in place. Unknown opcodes give an all-zero record;
// unsupported operations give legal = 0 with operation 0 and the operand
// fields still extracted.
module rv32im_instruction_decoder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [31:0]                       s_tdata,  // instruction[31:0]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // format_kind[2:0], issue_unit[5:3], operation[9:6], legal[10],
  // src1_reg[15:11], src2_reg[20:16], dest_reg[25:21], immediate[57:26],
  // uses_immediate[58], uses_src1[59], uses_src2[60], uses_dest[61], zero
  output logic [rvdec_pkg::OUT_BYTES*8-1:0] m_tdata
);
  import rvdec_pkg::*;

  logic        in_valid;
  logic [31:0] in_word;
  logic        out_valid;
  decode_t     out_rec;
  decode_t     dec_rec;
  logic        out_free;

  // Decode the registered word
  rvdec_core u_core (
    .instruction (in_word),
    .result      (dec_rec)
  );

  // Result stage can load when empty or being drained
  assign out_free = !out_valid || m_tready;
  assign s_tready = !in_valid || out_free;

  // Advance the two-stage pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (out_free) begin
        out_valid <= in_valid;
      end
    end
  end

  // Capture payloads on transfer
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_word <= s_tdata;
    end
    if (in_valid && out_free) begin
      out_rec <= dec_rec;
    end
  end

  // Pack the record, first field lowest
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_BYTES*8-RESULT_BITS){1'b0}},
                     out_rec.uses_dest, out_rec.uses_src2, out_rec.uses_src1,
                     out_rec.uses_immediate, out_rec.immediate, out_rec.dest_reg,
                     out_rec.src2_reg, out_rec.src1_reg, out_rec.legal,
                     out_rec.operation, out_rec.issue_unit, out_rec.format_kind};

  // An illegal record never carries an operation code
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_rec.legal |-> out_rec.operation == 4'd0)
    else $error("illegal record with non-zero operation");

  // An unknown format yields an empty record
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_rec.format_kind == FMT_NONE |->
      !out_rec.legal && out_rec.immediate == 32'd0 && out_rec.issue_unit == UNIT_ALU)
    else $error("unknown format with non-empty record");

  // Multiply/divide only comes from register-register words
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_rec.issue_unit == UNIT_MDU |-> out_rec.format_kind == FMT_R)
    else $error("mul/div outside R format");

  // A held input word stays put while the result stage is blocked
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_free |=> in_valid && $stable(in_word))
    else $error("input stage lost a word under back-pressure");

  // A stalled result is not replaced
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_tready |=> out_valid && $stable(out_rec))
    else $error("result register changed while stalled");

endmodule

[tb/sv/tb_rv32im_instruction_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rv32im_instruction_decoder
// Self-checking bench for the streaming RV32IM instruction decoder.
// ----------------------------------------------------------------------------
// Feeds instruction words through the slave stream and checks every decoded
// record on the master stream against a local decoder model, in order.
// A short table of hand-picked words opens the run: extremes of the immediate
// encodings, the illegal funct3/funct7 corners and unknown opcodes. Random
// words follow, mostly well-formed with random operand bits, the rest pure
// noise. Both stream sides idle at random, with one long downstream stall so
// that the pipeline fills and pushes back on its input.
// ----------------------------------------------------------------------------
module tb_rv32im_instruction_decoder;
  import rvdec_pkg::*;

  localparam int CYCLE_LIMIT      = 200000;
  localparam int RANDOM_PER_PHASE = 430;
  localparam int LONG_HOLD        = 64;
  localparam int DRAIN_CYCLES     = 8;
  localparam int REPORT_LIMIT     = 10;

  // funct3 values that pick an alternative decode
  localparam logic [2:0] F3_ADDSUB = 3'd0;
  localparam logic [2:0] F3_SLL    = 3'd1;
  localparam logic [2:0] F3_SHR    = 3'd5;

  // Per-funct3 operation tables (index 0 in the lowest slot) and legal masks
  localparam logic [7:0][3:0] ALU_BY_F3 = {ALU_AND, ALU_OR, ALU_SRL, ALU_XOR,
                                           ALU_SLT_U, ALU_SLT, ALU_SLL, ALU_ADD};
  localparam logic [7:0][3:0] LOAD_BY_F3 = {LD_LB, LD_LB, LD_LHU, LD_LBU,
                                            LD_LB, LD_LW, LD_LH, LD_LB};
  localparam logic [7:0]      LOAD_OK    = 8'b0011_0111;
  localparam logic [7:0][3:0] BRANCH_BY_F3 = {JMP_BGEU, JMP_BLTU, JMP_BGE, JMP_BLT,
                                              JMP_JAL, JMP_JAL, JMP_BNE, JMP_BEQ};
  localparam logic [7:0]      BRANCH_OK    = 8'b1111_0011;
  localparam logic [7:0][3:0] STORE_BY_F3 = {ST_SB, ST_SB, ST_SB, ST_SB,
                                             ST_SB, ST_SW, ST_SH, ST_SB};
  localparam logic [7:0]      STORE_OK    = 8'b0000_0111;
  localparam logic [7:0][3:0] CSR_BY_F3 = {CSR_SYS, CSR_SYS, CSR_SYS, CSR_SYS,
                                           CSR_RC, CSR_RS, CSR_RW, CSR_SYS};
  localparam logic [7:0]      CSR_OK    = 8'b0000_1111;
  localparam logic [7:0][3:0] MDU_BY_F3 = {MDU_MUL, MDU_REM, MDU_DIVU, MDU_DIV,
                                           MDU_MUL, MDU_MUL, MDU_MUL, MDU_MUL};
  localparam logic [7:0]      MDU_OK    = 8'b0111_0001;
  localparam logic [7:0]      JALR_OK   = 8'b0000_0001;

  localparam logic [9:0][6:0] KNOWN_OPCODES = {OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_JALR,
                                               OPC_LOAD, OPC_OPIMM, OPC_SYSTEM,
                                               OPC_BRANCH, OPC_STORE, OPC_OP};

  typedef struct {
    logic [31:0] word;
    decode_t     rec;
  } pending_decode_t;

  typedef struct {
    logic [31:0] word;
    bit          typed;
    decode_t     rec;
  } directed_case_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [31:0]              s_tdata = '0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OUT_BYTES*8-1:0]   m_tdata;

  pending_decode_t pending_decodes[$];
  directed_case_t  directed_words[$];
  int              mismatches = 0;
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  logic            hold_request = 1'b0;
  int              cycle_count = 0;

  rv32im_instruction_decoder u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ALU operation for funct3/funct7; register form checks funct7 more strictly
  function automatic logic alu_lookup(input logic [2:0] f3, input logic [6:0] f7,
                                      input logic reg_form, output logic [3:0] op);
    logic any_f7;
    logic ok;
    any_f7 = !reg_form || (f7 == F7_BASE);
    op = ALU_BY_F3[f3];
    case (f3)
      F3_ADDSUB: begin
        if (reg_form && f7 == F7_ALT) begin
          op = ALU_SUB;
          ok = 1'b1;
        end else begin
          ok = any_f7;
        end
      end
      F3_SLL: ok = (f7 == F7_BASE);
      F3_SHR: begin
        if (f7 == F7_ALT) op = ALU_SRA;
        ok = (f7 == F7_BASE) || (f7 == F7_ALT);
      end
      default: ok = any_f7;
    endcase
    return ok;
  endfunction

  // Decoded record for one instruction word
  function automatic decode_t decode_instruction(input logic [31:0] w);
    decode_t    d;
    logic [6:0] opc;
    logic [6:0] f7;
    logic [2:0] f3;
    logic [3:0] op;
    logic       ok;
    d   = '0;
    opc = w[6:0];
    f3  = w[14:12];
    f7  = w[31:25];
    op  = '0;
    ok  = 1'b0;
    case (opc)
      OPC_LUI, OPC_AUIPC: begin
        d.format_kind    = FMT_U;
        d.issue_unit     = UNIT_ALU;
        op               = (opc == OPC_LUI) ? ALU_LUI : ALU_AUIPC;
        ok               = 1'b1;
        d.immediate      = w & UPPER_MASK;
        d.uses_immediate = 1'b1;
        d.uses_dest      = 1'b1;
      end
      OPC_JAL: begin
        d.format_kind    = FMT_J;
        d.issue_unit     = UNIT_JUMP;
        op               = JMP_JAL;
        ok               = 1'b1;
        d.immediate      = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        d.uses_immediate = 1'b1;
        d.uses_dest      = 1'b1;
      end
      OPC_JALR, OPC_LOAD, OPC_OPIMM, OPC_SYSTEM: begin
        d.format_kind    = FMT_I;
        d.uses_immediate = 1'b1;
        d.uses_src1      = 1'b1;
        d.uses_dest      = 1'b1;
        d.immediate      = {{20{w[31]}}, w[31:20]};
        case (opc)
          OPC_JALR: begin
            d.issue_unit = UNIT_JUMP;
            op = JMP_JALR;
            ok = JALR_OK[f3];
          end
          OPC_LOAD: begin
            d.issue_unit = UNIT_LOAD;
            op = LOAD_BY_F3[f3];
            ok = LOAD_OK[f3];
          end
          OPC_OPIMM: begin
            d.issue_unit = UNIT_ALU;
            // immediate shifts carry only the shift amount
            if (f3 == F3_SLL || f3 == F3_SHR) d.immediate = {27'd0, w[24:20]};
            ok = alu_lookup(f3, f7, 1'b0, op);
          end
          default: begin
            d.issue_unit = UNIT_CSR;
            op = CSR_BY_F3[f3];
            ok = CSR_OK[f3];
          end
        endcase
      end
      OPC_BRANCH: begin
        d.format_kind    = FMT_B;
        d.issue_unit     = UNIT_JUMP;
        d.uses_src1      = 1'b1;
        d.uses_src2      = 1'b1;
        d.uses_immediate = 1'b1;
        op               = BRANCH_BY_F3[f3];
        ok               = BRANCH_OK[f3];
        d.immediate      = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      end
      OPC_STORE: begin
        d.format_kind    = FMT_S;
        d.issue_unit     = UNIT_STORE;
        d.uses_src1      = 1'b1;
        d.uses_src2      = 1'b1;
        d.uses_immediate = 1'b1;
        op               = STORE_BY_F3[f3];
        ok               = STORE_OK[f3];
        d.immediate      = {{20{w[31]}}, w[31:25], w[11:7]};
      end
      OPC_OP: begin
        d.format_kind = FMT_R;
        d.uses_src1   = 1'b1;
        d.uses_src2   = 1'b1;
        d.uses_dest   = 1'b1;
        if (f7 == F7_MULDIV) begin
          d.issue_unit = UNIT_MDU;
          op = MDU_BY_F3[f3];
          ok = MDU_OK[f3];
        end else begin
          d.issue_unit = UNIT_ALU;
          ok = alu_lookup(f3, f7, 1'b1, op);
        end
      end
      default: ;
    endcase
    d.operation = ok ? op : 4'd0;
    d.legal     = ok;
    d.src1_reg  = d.uses_src1 ? w[19:15] : 5'd0;
    d.src2_reg  = d.uses_src2 ? w[24:20] : 5'd0;
    d.dest_reg  = d.uses_dest ? w[11:7]  : 5'd0;
    return d;
  endfunction

  // Unpack the master stream bus, lowest field first
  function automatic decode_t unpack_record(input logic [OUT_BYTES*8-1:0] bus);
    decode_t d;
    d.format_kind    = bus[2:0];
    d.issue_unit     = bus[5:3];
    d.operation      = bus[9:6];
    d.legal          = bus[10];
    d.src1_reg       = bus[15:11];
    d.src2_reg       = bus[20:16];
    d.dest_reg       = bus[25:21];
    d.immediate      = bus[57:26];
    d.uses_immediate = bus[58];
    d.uses_src1      = bus[59];
    d.uses_src2      = bus[60];
    d.uses_dest      = bus[61];
    return d;
  endfunction

  function automatic string show_record(input decode_t d);
    return $sformatf("fmt %0d unit %0d op %0d legal %b rs1 %0d rs2 %0d rd %0d imm %h use %b%b%b%b",
                     d.format_kind, d.issue_unit, d.operation, d.legal, d.src1_reg,
                     d.src2_reg, d.dest_reg, d.immediate, d.uses_immediate,
                     d.uses_src1, d.uses_src2, d.uses_dest);
  endfunction

  function automatic string wrong_fields(input decode_t got, input decode_t want);
    string s;
    s = "";
    if (got.format_kind    !== want.format_kind)    s = {s, " format_kind"};
    if (got.issue_unit     !== want.issue_unit)     s = {s, " issue_unit"};
    if (got.operation      !== want.operation)      s = {s, " operation"};
    if (got.legal          !== want.legal)          s = {s, " legal"};
    if (got.src1_reg       !== want.src1_reg)       s = {s, " src1_reg"};
    if (got.src2_reg       !== want.src2_reg)       s = {s, " src2_reg"};
    if (got.dest_reg       !== want.dest_reg)       s = {s, " dest_reg"};
    if (got.immediate      !== want.immediate)      s = {s, " immediate"};
    if (got.uses_immediate !== want.uses_immediate) s = {s, " uses_immediate"};
    if (got.uses_src1      !== want.uses_src1)      s = {s, " uses_src1"};
    if (got.uses_src2      !== want.uses_src2)      s = {s, " uses_src2"};
    if (got.uses_dest      !== want.uses_dest)      s = {s, " uses_dest"};
    return s;
  endfunction

  // Compare each record transfer with the oldest outstanding decode
  always @(posedge clk) begin : check_records
    decode_t         got;
    pending_decode_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = unpack_record(m_tdata);
      if (pending_decodes.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected record: %s", show_record(got));
      end else begin
        want = pending_decodes.pop_front();
        if (got !== want.rec) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("decode of %h wrong in:%s", want.word, wrong_fields(got, want.rec));
            $display("  expected %s", show_record(want.rec));
            $display("  actual   %s", show_record(got));
          end
        end
      end
    end
  end

  // Downstream side: random stalls, plus one long hold-off on request
  initial begin : record_sink
    int held;
    bit hold_taken;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        m_tready   <= 1'b0;
        for (held = 0; held < LONG_HOLD; held++) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // Offer one word, idling first at random; record its decode once taken
  task automatic send_word(input logic [31:0] w, input bit typed, input decode_t rec);
    pending_decode_t entry;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    entry.word = w;
    entry.rec  = typed ? rec : decode_instruction(w);
    pending_decodes.push_back(entry);
  endtask

  // Mostly well-formed words of a known opcode with a biased funct7
  function automatic logic [31:0] random_word();
    logic [31:0] w;
    int          pick;
    w = $urandom();
    if ($urandom_range(99) < 12) return w;
    w[6:0] = KNOWN_OPCODES[$urandom_range(9)];
    pick = $urandom_range(9);
    if (pick < 4)      w[31:25] = F7_BASE;
    else if (pick < 6) w[31:25] = F7_ALT;
    else if (pick < 8) w[31:25] = F7_MULDIV;
    return w;
  endfunction

  // Hold the input off until every outstanding decode has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_decodes.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input bit long_hold);
    int n;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    if (long_hold) hold_request <= 1'b1;
    for (n = 0; n < RANDOM_PER_PHASE; n++) send_word(random_word(), 1'b0, '0);
    drain();
  endtask

  function automatic void add_case(input logic [31:0] w, input bit typed, input decode_t rec);
    directed_case_t c;
    c.word  = w;
    c.typed = typed;
    c.rec   = rec;
    directed_words.push_back(c);
  endfunction

  // Stimulus
  initial begin : stimulus
    int i;
    // unknown opcodes, all bits low and all bits high
    add_case(32'h0000_0000, 1'b1, '0);
    add_case(32'hFFFF_FFFF, 1'b1, '0);
    // upper immediates at both extremes
    add_case({20'hFFFFF, 5'd31, OPC_LUI}, 1'b1,
             '{FMT_U, UNIT_ALU, ALU_LUI, 1'b1, 5'd0, 5'd0, 5'd31, UPPER_MASK,
               1'b1, 1'b0, 1'b0, 1'b1});
    add_case({20'h00000, 5'd0, OPC_AUIPC}, 1'b1,
             '{FMT_U, UNIT_ALU, ALU_AUIPC, 1'b1, 5'd0, 5'd0, 5'd0, 32'd0,
               1'b1, 1'b0, 1'b0, 1'b1});
    // CSR funct3 beyond CSRRC is illegal, operands still extracted
    add_case({12'hFFF, 5'd31, 3'd4, 5'd31, OPC_SYSTEM}, 1'b1,
             '{FMT_I, UNIT_CSR, CSR_SYS, 1'b0, 5'd31, 5'd0, 5'd31, 32'hFFFF_FFFF,
               1'b1, 1'b1, 1'b0, 1'b1});
    // jump offsets at the negative and positive extremes, and all bits set
    add_case({1'b1, 10'h000, 1'b0, 8'h00, 5'd0, OPC_JAL}, 1'b0, '0);
    add_case({1'b0, 10'h3FF, 1'b1, 8'hFF, 5'd0, OPC_JAL}, 1'b0, '0);
    add_case({25'h1FF_FFFF, OPC_JAL}, 1'b0, '0);
    // JALR legal only with funct3 zero
    add_case({12'h800, 5'd1, 3'd0, 5'd2, OPC_JALR}, 1'b0, '0);
    add_case({12'h7FF, 5'd3, 3'd1, 5'd4, OPC_JALR}, 1'b0, '0);
    // load funct3 gap and the unsigned byte load
    add_case({12'h123, 5'd7, 3'd3, 5'd8, OPC_LOAD}, 1'b0, '0);
    add_case({12'hFFF, 5'd9, 3'd4, 5'd10, OPC_LOAD}, 1'b0, '0);
    // immediate ALU: largest positive, funct7 ignored, shift corners
    add_case({12'h7FF, 5'd5, 3'd0, 5'd6, OPC_OPIMM}, 1'b0, '0);
    add_case({7'h7F, 5'd31, 5'd2, 3'd3, 5'd3, OPC_OPIMM}, 1'b0, '0);
    add_case({7'h00, 5'd31, 5'd1, 3'd1, 5'd1, OPC_OPIMM}, 1'b0, '0);
    add_case({7'h20, 5'd4, 5'd1, 3'd1, 5'd1, OPC_OPIMM}, 1'b0, '0);
    add_case({7'h20, 5'd31, 5'd11, 3'd5, 5'd12, OPC_OPIMM}, 1'b0, '0);
    add_case({7'h01, 5'd17, 5'd11, 3'd5, 5'd12, OPC_OPIMM}, 1'b0, '0);
    // system call word
    add_case({25'd0, OPC_SYSTEM}, 1'b0, '0);
    // branch offset at the negative extreme and a funct3 gap
    add_case({7'h40, 5'd31, 5'd31, 3'd0, 5'h00, OPC_BRANCH}, 1'b0, '0);
    add_case({7'h15, 5'd2, 5'd3, 3'd2, 5'h0A, OPC_BRANCH}, 1'b0, '0);
    // store offset at the positive extreme and an illegal width
    add_case({7'h3F, 5'd2, 5'd3, 3'd2, 5'h1F, OPC_STORE}, 1'b0, '0);
    add_case({7'h40, 5'd4, 5'd5, 3'd3, 5'h01, OPC_STORE}, 1'b0, '0);
    // register ALU with the alternate funct7 and a stray funct7
    add_case({7'h20, 5'd13, 5'd14, 3'd0, 5'd15, OPC_OP}, 1'b0, '0);
    add_case({7'h20, 5'd16, 5'd17, 3'd5, 5'd18, OPC_OP}, 1'b0, '0);
    add_case({7'h40, 5'd19, 5'd20, 3'd7, 5'd21, OPC_OP}, 1'b0, '0);
    // multiply/divide: supported and unsupported
    add_case({7'h01, 5'd22, 5'd23, 3'd0, 5'd24, OPC_OP}, 1'b0, '0);
    add_case({7'h01, 5'd25, 5'd26, 3'd1, 5'd27, OPC_OP}, 1'b0, '0);
    add_case({7'h01, 5'd28, 5'd29, 3'd7, 5'd30, OPC_OP}, 1'b0, '0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed table, then three random phases with different idling
    send_idle_pct = 31;
    recv_idle_pct = 82;
    for (i = 0; i < directed_words.size(); i++)
      send_word(directed_words[i].word, directed_words[i].typed, directed_words[i].rec);
    run_phase(31, 82, 1'b0);
    run_phase(82, 31, 1'b0);
    run_phase(0, 0, 1'b1);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
